FILE: sv/assert_macros.svh
// Assertion macros for the election block RTL.
// The including module must have a clock named clk and an active-low reset named rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CEF_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("consensus election assertion failed");
`define CEF_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("consensus election assertion failed");
`else
`define CEF_ASSERT(label, prop)
`define CEF_ASSERT_ALWAYS(label, prop)
`endif
`endif

FILE: sv/cef_pkg.sv
// Shared types, field widths, codes and reset values of the consensus election block.
// Used by cef_timer, consensus_election_fsm and the test files; depends on nothing else.
package cef_pkg;

  localparam int TERM_BITS  = 32;
  localparam int ID_W       = 4;
  localparam int SIZE_W     = 5;
  localparam int TICK_W     = 16;
  localparam int TMO_W      = TICK_W + 1;
  localparam int VOTE_W     = 5;
  localparam int FUNC_W     = 3;
  localparam int LFSR_W     = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef logic [TERM_BITS-1:0] term_t;

  localparam term_t              TERM_MAX  = '1;
  localparam logic [VOTE_W-1:0]  VOTE_NONE = '1;
  localparam logic [VOTE_W-1:0]  VOTES_MAX = '1;
  localparam logic [TICK_W-1:0]  TICKS_MAX = '1;
  localparam logic [LFSR_W-1:0]  LFSR_TAPS = 16'hB400;

  localparam logic [FUNC_W-1:0] FUNC_TICK       = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_VOTE_REQ   = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_HEARTBEAT  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_VOTE_REPLY = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_BEAT_REPLY = 3'd4;

  localparam logic [CFG_ADDR_W-1:0] CFG_NODE_ID      = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_CLUSTER_SIZE = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_HB_PERIOD    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_TIMEOUT_MIN  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_TIMEOUT_SPAN = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_RANDOM_SEED  = 3'd5;

  localparam logic [ID_W-1:0]   RST_NODE_ID      = 4'd0;
  localparam logic [SIZE_W-1:0] RST_CLUSTER_SIZE = 5'd3;
  localparam logic [TICK_W-1:0] RST_HB_PERIOD    = 16'd100;
  localparam logic [TICK_W-1:0] RST_TIMEOUT_MIN  = 16'd250;
  localparam logic [TICK_W-1:0] RST_TIMEOUT_SPAN = 16'd250;
  localparam logic [LFSR_W-1:0] RST_SEED         = 16'd44257;

  localparam logic [LFSR_W-1:0] RST_LFSR = (RST_SEED == '0) ? LFSR_W'(1) : RST_SEED;
  localparam longint unsigned   RST_PROD = 64'(RST_LFSR) * 64'(RST_TIMEOUT_SPAN);
  localparam logic [TMO_W-1:0]  RST_TIMEOUT =
    TMO_W'(64'(RST_TIMEOUT_MIN) + (RST_PROD >> LFSR_W));

  typedef struct packed {
    logic restart;
    logic load_min;
    logic load_span;
    logic load_seed;
  } timer_ctrl_t;

endpackage

FILE: sv/cef_timer.sv
// Randomized election timeout: the LFSR, the timeout range registers and the scaled timeout.
// Depends on cef_pkg for widths, reset values and the timer_ctrl_t control struct.
module cef_timer
  import cef_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  timer_ctrl_t           ctrl,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic [TMO_W-1:0]      timeout
);

  logic [LFSR_W-1:0]   lfsr_r;
  logic [LFSR_W-1:0]   lfsr_step;
  logic [LFSR_W-1:0]   seed_load;
  logic [LFSR_W-1:0]   lfsr_sel;
  logic [TICK_W-1:0]   min_r;
  logic [TICK_W-1:0]   span_r;
  logic [TICK_W-1:0]   min_sel;
  logic [TICK_W-1:0]   span_sel;
  logic [TMO_W-1:0]    timeout_r;
  logic [TMO_W-1:0]    timeout_nxt;
  logic [2*LFSR_W-1:0] prod;
  logic                cfg_load;

  always_comb begin
    cfg_load  = ctrl.load_min | ctrl.load_span | ctrl.load_seed;
    lfsr_step = (lfsr_r >> 1) ^ (lfsr_r[0] ? LFSR_TAPS : '0);
    seed_load = (cfg_wdata == '0) ? LFSR_W'(1) : cfg_wdata;
    min_sel   = ctrl.load_min  ? cfg_wdata : min_r;
    span_sel  = ctrl.load_span ? cfg_wdata : span_r;
    if (cfg_load) begin
      lfsr_sel = ctrl.load_seed ? seed_load : lfsr_r;
    end else begin
      lfsr_sel = lfsr_step;
    end
    prod        = (2*LFSR_W)'(lfsr_sel) * (2*LFSR_W)'(span_sel);
    timeout_nxt = TMO_W'(min_sel) + TMO_W'(prod[2*LFSR_W-1:LFSR_W]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r    <= RST_LFSR;
      min_r     <= RST_TIMEOUT_MIN;
      span_r    <= RST_TIMEOUT_SPAN;
      timeout_r <= RST_TIMEOUT;
    end else begin
      if (ctrl.load_min) begin
        min_r <= cfg_wdata;
      end
      if (ctrl.load_span) begin
        span_r <= cfg_wdata;
      end
      if (cfg_load || ctrl.restart) begin
        lfsr_r    <= lfsr_sel;
        timeout_r <= timeout_nxt;
      end
    end
  end

  assign timeout = timeout_r;

endmodule

FILE: sv/consensus_election_fsm.sv
// Leader election for one node: each accepted event (tick, vote request, heartbeat, vote
// reply, heartbeat reply) updates role, term, vote, leader and timers in the cycle it is
// accepted, and its single result transaction is registered in main_r, or in skid_r while
// main_r waits on out_stall. The block takes one transaction per clock while in_stall is low,
// bounded by the state update and the 16x16 timeout multiply in cef_timer. A two-entry output
// buffer keeps in_stall a registered signal, so input is taken while one finished result is
// still waiting on out_stall. Depends on cef_pkg, cef_timer and assert_macros.svh.
`include "assert_macros.svh"

module consensus_election_fsm
  import cef_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [FUNC_W-1:0]     in_func,
  input  term_t                 in_msg_term,
  input  logic [ID_W-1:0]       in_sender_id,
  input  logic                  in_granted,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_reply_valid,
  output term_t                 out_reply_term,
  output logic                  out_reply_ok,
  output logic                  out_start_election,
  output logic                  out_send_heartbeats,
  output logic [1:0]            out_role,
  output term_t                 out_term_now,
  output logic                  out_leader_known,
  output logic [ID_W-1:0]       out_leader_now,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [1:0] {
    ROLE_FOLLOWER  = 2'd0,
    ROLE_CANDIDATE = 2'd1,
    ROLE_LEADER    = 2'd2
  } role_t;

  typedef struct packed {
    logic            reply_valid;
    term_t           reply_term;
    logic            reply_ok;
    logic            start_election;
    logic            send_heartbeats;
    role_t           role;
    term_t           term_now;
    logic            leader_known;
    logic [ID_W-1:0] leader_now;
  } result_t;

  role_t               role_r, role_nxt;
  term_t               term_r, term_nxt;
  logic [VOTE_W-1:0]   vote_r, vote_nxt;
  logic [ID_W-1:0]     lid_r, lid_nxt;
  logic                lv_r, lv_nxt;
  logic [TICK_W-1:0]   elapsed_r, elapsed_nxt;
  logic [VOTE_W-1:0]   votes_r, votes_nxt;
  logic [ID_W-1:0]     node_id_r;
  logic [SIZE_W-1:0]   size_r;
  logic [TICK_W-1:0]   hb_r;
  result_t             main_r, skid_r, res;
  logic                main_v_r, skid_v_r;

  logic                accept;
  logic                take;
  logic                higher;
  logic                restart;
  logic                beats;
  logic [SIZE_W-1:0]   half;
  logic [TICK_W-1:0]   elapsed_inc;
  logic [VOTE_W-1:0]   votes_inc;
  logic [TMO_W-1:0]    timeout;
  timer_ctrl_t         tctrl;

  cef_timer u_timer (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (tctrl),
    .cfg_wdata (cfg_wdata),
    .timeout   (timeout)
  );

  always_comb begin
    accept      = in_valid && !skid_v_r;
    take        = main_v_r && !out_stall;
    half        = size_r >> 1;
    elapsed_inc = (elapsed_r == TICKS_MAX) ? elapsed_r : elapsed_r + TICK_W'(1);
    votes_inc   = (votes_r == VOTES_MAX) ? votes_r : votes_r + VOTE_W'(1);
    higher      = (in_func inside {FUNC_VOTE_REQ, FUNC_HEARTBEAT, FUNC_VOTE_REPLY,
                                   FUNC_BEAT_REPLY}) && (in_msg_term > term_r);

    role_nxt    = role_r;
    term_nxt    = term_r;
    vote_nxt    = vote_r;
    lid_nxt     = lid_r;
    lv_nxt      = lv_r;
    elapsed_nxt = elapsed_r;
    votes_nxt   = votes_r;
    restart     = 1'b0;
    beats       = 1'b0;
    res         = '0;

    if (higher) begin
      role_nxt  = ROLE_FOLLOWER;
      term_nxt  = in_msg_term;
      vote_nxt  = VOTE_NONE;
      lv_nxt    = 1'b0;
      lid_nxt   = '0;
      votes_nxt = '0;
    end

    case (in_func)
      FUNC_TICK: begin
        elapsed_nxt = elapsed_inc;
        if (role_r == ROLE_LEADER) begin
          if (elapsed_inc > hb_r) begin
            beats       = 1'b1;
            elapsed_nxt = '0;
          end
        end else if (TMO_W'(elapsed_inc) > timeout) begin
          role_nxt           = ROLE_CANDIDATE;
          term_nxt           = (term_r == TERM_MAX) ? term_r : term_r + term_t'(1);
          vote_nxt           = VOTE_W'(node_id_r);
          lv_nxt             = 1'b0;
          lid_nxt            = '0;
          votes_nxt          = VOTE_W'(1);
          restart            = 1'b1;
          elapsed_nxt        = '0;
          res.start_election = 1'b1;
          if (half == '0) begin
            role_nxt = ROLE_LEADER;
            lid_nxt  = node_id_r;
            lv_nxt   = 1'b1;
            beats    = 1'b1;
          end
        end
      end
      FUNC_VOTE_REQ: begin
        res.reply_valid = 1'b1;
        res.reply_term  = term_nxt;
        if (in_msg_term >= term_nxt &&
            (vote_nxt == VOTE_NONE || vote_nxt == VOTE_W'(in_sender_id))) begin
          res.reply_ok = 1'b1;
          vote_nxt     = VOTE_W'(in_sender_id);
          restart      = 1'b1;
          elapsed_nxt  = '0;
        end
      end
      FUNC_HEARTBEAT: begin
        res.reply_valid = 1'b1;
        res.reply_term  = term_nxt;
        if (in_msg_term >= term_nxt) begin
          if (role_nxt == ROLE_CANDIDATE) begin
            role_nxt  = ROLE_FOLLOWER;
            votes_nxt = '0;
          end
          lid_nxt      = in_sender_id;
          lv_nxt       = 1'b1;
          restart      = 1'b1;
          elapsed_nxt  = '0;
          res.reply_ok = 1'b1;
        end
      end
      FUNC_VOTE_REPLY: begin
        if (in_granted && role_nxt == ROLE_CANDIDATE && in_msg_term == term_nxt) begin
          votes_nxt = votes_inc;
          if (votes_inc > VOTE_W'(half)) begin
            role_nxt    = ROLE_LEADER;
            lid_nxt     = node_id_r;
            lv_nxt      = 1'b1;
            elapsed_nxt = '0;
            beats       = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    res.send_heartbeats = beats;
    res.role            = role_nxt;
    res.term_now        = term_nxt;
    res.leader_known    = lv_nxt;
    res.leader_now      = lv_nxt ? lid_nxt : '0;

    tctrl.restart   = accept && restart;
    tctrl.load_min  = cfg_we && (cfg_addr == CFG_TIMEOUT_MIN);
    tctrl.load_span = cfg_we && (cfg_addr == CFG_TIMEOUT_SPAN);
    tctrl.load_seed = cfg_we && (cfg_addr == CFG_RANDOM_SEED);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      role_r    <= ROLE_FOLLOWER;
      term_r    <= '0;
      vote_r    <= VOTE_NONE;
      lid_r     <= '0;
      lv_r      <= 1'b0;
      elapsed_r <= '0;
      votes_r   <= '0;
      node_id_r <= RST_NODE_ID;
      size_r    <= RST_CLUSTER_SIZE;
      hb_r      <= RST_HB_PERIOD;
      main_r    <= '0;
      skid_r    <= '0;
      main_v_r  <= 1'b0;
      skid_v_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_NODE_ID:      node_id_r <= cfg_wdata[ID_W-1:0];
          CFG_CLUSTER_SIZE: size_r    <= cfg_wdata[SIZE_W-1:0];
          CFG_HB_PERIOD:    hb_r      <= cfg_wdata[TICK_W-1:0];
          default: begin
          end
        endcase
      end
      if (accept) begin
        role_r    <= role_nxt;
        term_r    <= term_nxt;
        vote_r    <= vote_nxt;
        lid_r     <= lid_nxt;
        lv_r      <= lv_nxt;
        elapsed_r <= elapsed_nxt;
        votes_r   <= votes_nxt;
      end
      if (skid_v_r) begin
        if (take) begin
          main_r   <= skid_r;
          skid_v_r <= 1'b0;
        end
      end else if (accept) begin
        if (!main_v_r || take) begin
          main_r   <= res;
          main_v_r <= 1'b1;
        end else begin
          skid_r   <= res;
          skid_v_r <= 1'b1;
        end
      end else if (take) begin
        main_v_r <= 1'b0;
      end
    end
  end

  assign in_stall            = skid_v_r;
  assign out_valid           = main_v_r;
  assign out_reply_valid     = main_r.reply_valid;
  assign out_reply_term      = main_r.reply_term;
  assign out_reply_ok        = main_r.reply_ok;
  assign out_start_election  = main_r.start_election;
  assign out_send_heartbeats = main_r.send_heartbeats;
  assign out_role            = main_r.role;
  assign out_term_now        = main_r.term_now;
  assign out_leader_known    = main_r.leader_known;
  assign out_leader_now      = main_r.leader_now;

  `CEF_ASSERT(a_skid_needs_main, skid_v_r |-> main_v_r)
  `CEF_ASSERT(a_skid_fills_on_stall, (accept && main_v_r && out_stall) |=> skid_v_r)
  `CEF_ASSERT(a_leader_is_known, (role_r == ROLE_LEADER) |-> lv_r)
  `CEF_ASSERT(a_candidate_has_votes, (role_r == ROLE_CANDIDATE) |-> (votes_r != '0))
  `CEF_ASSERT(a_term_never_drops, $past(rst_n) |-> (term_r >= $past(term_r)))
  `CEF_ASSERT_ALWAYS(a_reset_empties_output, !rst_n |=> (!main_v_r && !skid_v_r))

endmodule

FILE: test/election_status_checker.sv
`timescale 1ns / 1ps
// Status checker for the consensus election block: it follows every accepted event and
// register write with its own model of the node and compares each result transaction in order.
// Depends on cef_pkg.
module election_status_checker
  import cef_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [FUNC_W-1:0]     in_func,
  input  term_t                 in_msg_term,
  input  logic [ID_W-1:0]       in_sender_id,
  input  logic                  in_granted,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic                  out_reply_valid,
  input  term_t                 out_reply_term,
  input  logic                  out_reply_ok,
  input  logic                  out_start_election,
  input  logic                  out_send_heartbeats,
  input  logic [1:0]            out_role,
  input  term_t                 out_term_now,
  input  logic                  out_leader_known,
  input  logic [ID_W-1:0]       out_leader_now,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending
);

  localparam logic [1:0] ROLE_FOLLOWER  = 2'd0;
  localparam logic [1:0] ROLE_CANDIDATE = 2'd1;
  localparam logic [1:0] ROLE_LEADER    = 2'd2;
  localparam int         SHOWN_MAX      = 10;

  typedef struct packed {
    logic            reply_valid;
    term_t           reply_term;
    logic            reply_ok;
    logic            start_election;
    logic            send_heartbeats;
    logic [1:0]      role;
    term_t           term_now;
    logic            leader_known;
    logic [ID_W-1:0] leader_now;
  } node_status_t;

  logic [ID_W-1:0]   my_id;
  logic [SIZE_W-1:0] members;
  logic [TICK_W-1:0] beat_period;
  logic [TICK_W-1:0] tmo_min;
  logic [TICK_W-1:0] tmo_span;
  logic [LFSR_W-1:0] seed;

  logic [1:0]        role;
  term_t             term;
  logic [VOTE_W-1:0] voted_for;
  logic [ID_W-1:0]   leader;
  logic              leader_ok;
  logic [TICK_W-1:0] elapsed;
  logic [TMO_W-1:0]  timeout;
  logic [VOTE_W-1:0] votes;
  logic [LFSR_W-1:0] lfsr;

  node_status_t expected_status [$];

  function automatic logic [TMO_W-1:0] timeout_from_lfsr();
    logic [2*LFSR_W-1:0] product;
    product = lfsr * tmo_span;
    return TMO_W'(tmo_min) + TMO_W'(product[2*LFSR_W-1:LFSR_W]);
  endfunction

  function automatic logic has_majority();
    return votes > VOTE_W'(members >> 1);
  endfunction

  task automatic restart_timer();
    lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
    timeout = timeout_from_lfsr();
    elapsed = '0;
  endtask

  task automatic take_leadership();
    role = ROLE_LEADER;
    leader = my_id;
    leader_ok = 1'b1;
    elapsed = '0;
  endtask

  task automatic predict_event(input logic [FUNC_W-1:0] func, input term_t msg_term,
                               input logic [ID_W-1:0] sender, input logic granted,
                               output node_status_t status);
    logic  answered;
    logic  ok;
    logic  elect;
    logic  beats;
    term_t answer_term;
    answered = 1'b0;
    ok = 1'b0;
    elect = 1'b0;
    beats = 1'b0;
    answer_term = '0;
    if (func >= FUNC_VOTE_REQ && func <= FUNC_BEAT_REPLY && msg_term > term) begin
      role = ROLE_FOLLOWER;
      term = msg_term;
      voted_for = VOTE_NONE;
      leader_ok = 1'b0;
      leader = '0;
      votes = '0;
    end
    case (func)
      FUNC_TICK: begin
        if (elapsed != TICKS_MAX) elapsed = elapsed + 1'b1;
        if (role == ROLE_LEADER) begin
          if (elapsed > beat_period) begin
            beats = 1'b1;
            elapsed = '0;
          end
        end else if ({1'b0, elapsed} > timeout) begin
          role = ROLE_CANDIDATE;
          if (term != TERM_MAX) term = term + 1'b1;
          voted_for = {1'b0, my_id};
          leader_ok = 1'b0;
          leader = '0;
          votes = VOTE_W'(1);
          restart_timer();
          elect = 1'b1;
          if (has_majority()) begin
            take_leadership();
            beats = 1'b1;
          end
        end
      end
      FUNC_VOTE_REQ: begin
        answered = 1'b1;
        if (msg_term >= term && (voted_for == VOTE_NONE || voted_for == {1'b0, sender})) begin
          ok = 1'b1;
          voted_for = {1'b0, sender};
          restart_timer();
        end
        answer_term = term;
      end
      FUNC_HEARTBEAT: begin
        answered = 1'b1;
        if (msg_term >= term) begin
          if (role == ROLE_CANDIDATE) begin
            role = ROLE_FOLLOWER;
            votes = '0;
          end
          leader = sender;
          leader_ok = 1'b1;
          restart_timer();
          ok = 1'b1;
        end
        answer_term = term;
      end
      FUNC_VOTE_REPLY: begin
        if (granted && role == ROLE_CANDIDATE && msg_term == term) begin
          if (votes != VOTES_MAX) votes = votes + 1'b1;
          if (has_majority()) begin
            take_leadership();
            beats = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    status.reply_valid = answered;
    status.reply_term = answer_term;
    status.reply_ok = ok;
    status.start_election = elect;
    status.send_heartbeats = beats;
    status.role = role;
    status.term_now = term;
    status.leader_known = leader_ok;
    status.leader_now = leader_ok ? leader : '0;
  endtask

  task automatic note_failure(input string what, input node_status_t want,
                              input node_status_t got);
    fail_count++;
    if (fail_count <= SHOWN_MAX) begin
      $display("%0t: %s: expected %p, got %p", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    node_status_t got;
    node_status_t want;
    if (!rst_n) begin
      my_id = RST_NODE_ID;
      members = RST_CLUSTER_SIZE;
      beat_period = RST_HB_PERIOD;
      tmo_min = RST_TIMEOUT_MIN;
      tmo_span = RST_TIMEOUT_SPAN;
      seed = RST_SEED;
      role = ROLE_FOLLOWER;
      term = '0;
      voted_for = VOTE_NONE;
      leader = '0;
      leader_ok = 1'b0;
      elapsed = '0;
      votes = '0;
      lfsr = (seed == '0) ? LFSR_W'(1) : seed;
      timeout = timeout_from_lfsr();
      expected_status.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_reply_valid, out_reply_term, out_reply_ok, out_start_election,
               out_send_heartbeats, out_role, out_term_now, out_leader_known,
               out_leader_now};
        if (expected_status.size() == 0) begin
          note_failure("result transaction with no event pending", '0, got);
        end else begin
          want = expected_status.pop_front();
          if (got !== want) note_failure("result mismatch", want, got);
        end
      end
      if (cfg_we) begin
        case (cfg_addr)
          CFG_NODE_ID: my_id = cfg_wdata[ID_W-1:0];
          CFG_CLUSTER_SIZE: members = cfg_wdata[SIZE_W-1:0];
          CFG_HB_PERIOD: beat_period = cfg_wdata;
          CFG_TIMEOUT_MIN: begin
            tmo_min = cfg_wdata;
            timeout = timeout_from_lfsr();
          end
          CFG_TIMEOUT_SPAN: begin
            tmo_span = cfg_wdata;
            timeout = timeout_from_lfsr();
          end
          CFG_RANDOM_SEED: begin
            seed = cfg_wdata;
            lfsr = (seed == '0) ? LFSR_W'(1) : seed;
            timeout = timeout_from_lfsr();
          end
          default: begin
          end
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_event(in_func, in_msg_term, in_sender_id, in_granted, want);
        expected_status.push_back(want);
      end
    end
    pending = expected_status.size();
  end

endmodule

FILE: test/consensus_election_fsm_tb.sv
`timescale 1ns / 1ps
// Top of the consensus election testbench: clock, reset, register writes, event stimulus and
// output stalls, with election_status_checker doing all checking beside the block.
// Depends on cef_pkg, consensus_election_fsm and election_status_checker.
module consensus_election_fsm_tb;
  import cef_pkg::*;

  localparam int     CLK_HALF        = 4;
  localparam int     RESET_CYCLES    = 7;
  localparam int     ITEMS_PER_PHASE = 375;
  localparam int     RANDOM_PHASES   = 4;
  localparam int     LONG_TICKS      = 40;
  localparam int     VOTE_REPLIES    = 9;
  localparam int     DRAIN_CYCLES    = 8;
  localparam longint LIMIT_NS        = 10_000_000;

  localparam logic [FUNC_W-1:0] FUNC_RESERVED_A = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_RESERVED_C = 3'd7;

  typedef struct packed {
    logic [ID_W-1:0]   node_id;
    logic [SIZE_W-1:0] cluster_size;
    logic [TICK_W-1:0] hb_period;
    logic [TICK_W-1:0] timeout_min;
    logic [TICK_W-1:0] timeout_span;
    logic [LFSR_W-1:0] seed;
  } election_cfg_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [FUNC_W-1:0]     in_func = FUNC_TICK;
  term_t                 in_msg_term = '0;
  logic [ID_W-1:0]       in_sender_id = '0;
  logic                  in_granted = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_reply_valid;
  term_t                 out_reply_term;
  logic                  out_reply_ok;
  logic                  out_start_election;
  logic                  out_send_heartbeats;
  logic [1:0]            out_role;
  term_t                 out_term_now;
  logic                  out_leader_known;
  logic [ID_W-1:0]       out_leader_now;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = CFG_NODE_ID;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  int                    fail_count;
  int                    pending;
  int                    idle_pct = 0;
  int                    stall_pct = 0;
  term_t                 seen_term = '0;

  consensus_election_fsm uut (.*);

  election_status_checker status_check (.*);

  always #(CLK_HALF) clk = ~clk;

  always @(negedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) seen_term <= out_term_now;
  end

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  task automatic apply_settings(input election_cfg_t c);
    write_reg(CFG_NODE_ID, CFG_DATA_W'(c.node_id));
    write_reg(CFG_CLUSTER_SIZE, CFG_DATA_W'(c.cluster_size));
    write_reg(CFG_HB_PERIOD, c.hb_period);
    write_reg(CFG_TIMEOUT_MIN, c.timeout_min);
    write_reg(CFG_TIMEOUT_SPAN, c.timeout_span);
    write_reg(CFG_RANDOM_SEED, c.seed);
    cfg_we <= 1'b0;
  endtask

  task automatic drive_event(input logic [FUNC_W-1:0] func, input term_t msg_term,
                             input logic [ID_W-1:0] sender, input logic granted);
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_msg_term <= msg_term;
    in_sender_id <= sender;
    in_granted <= granted;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  function automatic term_t pick_term();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return seen_term;
    if (pick < 70) return seen_term + 1'b1;
    if (pick < 82) return (seen_term != '0) ? seen_term - 1'b1 : seen_term;
    if (pick < 92) return seen_term + term_t'($urandom_range(2, 5));
    return '0;
  endfunction

  task automatic send_round(input int length);
    int                kind;
    int                pick;
    logic [FUNC_W-1:0] func;
    term_t             msg_term;
    logic [ID_W-1:0]   sender;
    logic              granted;
    kind = $urandom_range(0, 9);
    repeat (length) begin
      pick = $urandom_range(0, 99);
      sender = ID_W'($urandom_range(0, 15));
      granted = ($urandom_range(0, 99) < 80);
      msg_term = pick_term();
      if (kind < 5) begin
        func = (pick < 60) ? FUNC_TICK : (pick < 95) ? FUNC_VOTE_REPLY : FUNC_BEAT_REPLY;
      end else if (kind < 7) begin
        func = (pick < 25) ? FUNC_HEARTBEAT : (pick < 85) ? FUNC_TICK : FUNC_VOTE_REQ;
      end else if (kind < 9) begin
        func = (pick < 40) ? FUNC_VOTE_REQ : (pick < 60) ? FUNC_HEARTBEAT :
               (pick < 90) ? FUNC_TICK : FUNC_VOTE_REPLY;
      end else begin
        func = FUNC_W'($urandom_range(FUNC_TICK, FUNC_RESERVED_C));
        granted = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 30) msg_term = term_t'($urandom);
      end
      drive_event(func, msg_term, sender, granted);
    end
  endtask

  initial begin
    #(LIMIT_NS);
    $display("consensus_election_fsm_tb NOT OK");
    $finish;
  end

  initial begin
    election_cfg_t cfg;
    int            sent;
    int            len;
    logic          paused;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    drive_event(FUNC_RESERVED_A, 32'd7, 4'd1, 1'b0);
    drive_event(FUNC_RESERVED_C, TERM_MAX, 4'd15, 1'b1);
    drive_event(FUNC_TICK, '0, '0, 1'b0);
    drive_event(FUNC_VOTE_REQ, '0, 4'd3, 1'b0);
    drive_event(FUNC_VOTE_REQ, '0, 4'd5, 1'b0);
    drive_event(FUNC_VOTE_REQ, '0, 4'd3, 1'b0);
    drive_event(FUNC_HEARTBEAT, '0, 4'd15, 1'b0);
    drive_event(FUNC_BEAT_REPLY, '0, '0, 1'b1);
    drive_event(FUNC_VOTE_REPLY, '0, 4'd2, 1'b1);
    drive_event(FUNC_HEARTBEAT, 32'd5, 4'd9, 1'b0);
    drive_event(FUNC_VOTE_REQ, 32'd2, 4'd4, 1'b0);
    drive_event(FUNC_VOTE_REQ, 32'd6, 4'd4, 1'b1);

    wait_drained();
    apply_settings('{node_id: 4'd15, cluster_size: 5'd1, hb_period: 16'd1,
                     timeout_min: 16'd1, timeout_span: 16'd0, seed: 16'd0});
    repeat (4) drive_event(FUNC_TICK, '0, '0, 1'b0);
    drive_event(FUNC_HEARTBEAT, 32'd7, 4'd2, 1'b0);
    drive_event(FUNC_VOTE_REPLY, 32'd7, '0, 1'b1);
    drive_event(FUNC_HEARTBEAT, 32'd8, 4'd1, 1'b0);

    wait_drained();
    cfg = '{node_id: 4'd0, cluster_size: 5'd16, hb_period: 16'hFFFF,
            timeout_min: 16'hFFFF, timeout_span: 16'hFFFF, seed: 16'hFFFF};
    apply_settings(cfg);
    repeat (LONG_TICKS) drive_event(FUNC_TICK, term_t'($urandom), '0, 1'b0);
    wait_drained();
    cfg.timeout_min = 16'hFFFE;
    cfg.timeout_span = 16'd0;
    apply_settings(cfg);
    drive_event(FUNC_TICK, '0, '0, 1'b0);
    repeat (VOTE_REPLIES) drive_event(FUNC_VOTE_REPLY, 32'd9, 4'd6, 1'b1);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_drained();
      case (p)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 68;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 68;
        end
        default: begin
          idle_pct = 22;
          stall_pct = 22;
        end
      endcase
      cfg.node_id = ID_W'($urandom_range(0, 15));
      cfg.cluster_size = $urandom_range(0, 1) ? SIZE_W'($urandom_range(1, 5))
                                              : SIZE_W'($urandom_range(1, 16));
      cfg.hb_period = TICK_W'($urandom_range(1, 12));
      cfg.timeout_min = TICK_W'($urandom_range(1, 10));
      cfg.timeout_span = TICK_W'($urandom_range(0, 80));
      cfg.seed = LFSR_W'($urandom_range(1, 65535));
      apply_settings(cfg);
      sent = 0;
      paused = 1'b0;
      while (sent < ITEMS_PER_PHASE) begin
        len = $urandom_range(4, 30);
        send_round(len);
        sent += len;
        if (!paused && sent >= ITEMS_PER_PHASE / 2) begin
          wait_drained();
          paused = 1'b1;
        end
      end
    end

    wait_drained();
    idle_pct = 0;
    stall_pct = 0;
    apply_settings('{node_id: 4'd9, cluster_size: 5'd1, hb_period: 16'd1,
                     timeout_min: 16'd1, timeout_span: 16'd0, seed: 16'd1});
    drive_event(FUNC_HEARTBEAT, TERM_MAX, 4'd1, 1'b0);
    repeat (3) drive_event(FUNC_TICK, '0, '0, 1'b0);

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("consensus_election_fsm_tb OK");
    end else begin
      $display("consensus_election_fsm_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/cef_pkg.sv
sv/cef_timer.sv
sv/consensus_election_fsm.sv
test/election_status_checker.sv
test/consensus_election_fsm_tb.sv
